@@ hdl/bpss_pkg.sv @@
// ----------------------------------------------------------------------------
// bpss_pkg
// Shared widths, defaults and controller states for the best parent set
// subset dynamic program.
// ----------------------------------------------------------------------------
package bpss_pkg;

  // default build sizes
  localparam int DEF_MAX_NODES   = 10;
  localparam int DEF_SCORE_WIDTH = 32;

  // fixed field widths
  localparam int NODE_W    = 4;
  localparam int SET_W     = 10;
  localparam int CFG_W     = 4;
  localparam int CNT_W     = 5;
  localparam int NODE_SPAN = 1 << NODE_W;

  // controller states
  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } bpss_state_t;

  // isolate the lowest set bit of a member mask
  function automatic logic [SET_W-1:0] lowest_bit(input logic [SET_W-1:0] mask);
    lowest_bit = mask & (~mask + SET_W'(1));
  endfunction

endpackage

@@ hdl/bpss_ram.sv @@
// ----------------------------------------------------------------------------
// bpss_ram
// Single-port synchronous store for best set and best score per family,
// with a registered read.
// ----------------------------------------------------------------------------
module bpss_ram #(
  parameter int DEPTH  = 2,
  parameter int ADDR_W = 1,
  parameter int DATA_W = 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] addr,
  input  logic [DATA_W-1:0] wdata,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  // write and registered read share the one port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

@@ hdl/best_parent_set_subset_dp.sv @@
// Flow: one item at a time; a new input beat is taken only in idle, after the
//   last result is loaded, so a stalled result channel also holds the input.
// Steps: one store read per member, one to settle the last compare, one for
//   write-back; an empty or rejected subset goes from scan straight to the result.
// Reset: synchronous, clears the controller and out_valid and sets node_count
//   to MAX_NODES; the family store is not cleared and is undefined until written.
// ----------------------------------------------------------------------------
// best_parent_set_subset_dp
// Best parent set per family: scans the one-smaller subsets of each
// candidate set in a family store and keeps the best scoring one.
// ----------------------------------------------------------------------------
module best_parent_set_subset_dp #(
  parameter int MAX_NODES   = bpss_pkg::DEF_MAX_NODES,
  parameter int SCORE_WIDTH = bpss_pkg::DEF_SCORE_WIDTH
) (
  input  logic                          clk,
  input  logic                          rst,
  // configuration
  input  logic                          cfg_we,
  input  logic [bpss_pkg::CFG_W-1:0]    cfg_data,
  // input channel
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [bpss_pkg::NODE_W-1:0]   node,
  input  logic [bpss_pkg::SET_W-1:0]    subset,
  input  logic signed [SCORE_WIDTH-1:0] score,
  // result channel
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          valid_res,
  output logic [bpss_pkg::SET_W-1:0]    best_set,
  output logic signed [SCORE_WIDTH-1:0] best_score
);

  import bpss_pkg::*;

  localparam int NODE_AW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int ADDR_W  = NODE_AW + MAX_NODES;
  localparam int DEPTH   = MAX_NODES << MAX_NODES;
  localparam int DATA_W  = SET_W + SCORE_WIDTH;

  bpss_state_t state, state_next;

  logic [CNT_W-1:0]              node_count;
  logic [CNT_W-1:0]              n_act;
  logic                          in_ok;
  logic [NODE_SPAN-1:0]          sub_by_node;

  logic [NODE_W-1:0]             node_r;
  logic [SET_W-1:0]              sub_r;
  logic                          item_ok;
  logic [SET_W-1:0]              rem;
  logic [SET_W-1:0]              low;
  logic                          rd_pending;
  logic signed [SCORE_WIDTH-1:0] cur_score;
  logic [SET_W-1:0]              cur_set;

  logic                          rd_issue;
  logic                          load_out;
  logic                          ram_we;
  logic [ADDR_W-1:0]             ram_addr;
  logic [DATA_W-1:0]             ram_wdata;
  logic [DATA_W-1:0]             ram_rdata;
  logic signed [SCORE_WIDTH-1:0] rd_score;
  logic [SET_W-1:0]              rd_set;
  logic [SET_W+MAX_NODES-1:0]    rd_sub_wide;
  logic [SET_W+MAX_NODES-1:0]    wr_sub_wide;

  // node count register
  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= CNT_W'(MAX_NODES);
    end else if (cfg_we) begin
      node_count <= CNT_W'(cfg_data);
    end
  end

  // item checks: node in range, subset in range, node not its own parent
  assign n_act       = (node_count > CNT_W'(MAX_NODES)) ? CNT_W'(MAX_NODES) : node_count;
  assign sub_by_node = NODE_SPAN'(subset);
  assign in_ok       = (CNT_W'(node) < n_act) && ((subset >> n_act) == '0)
                       && !sub_by_node[node];

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (rem == '0 && !rd_pending) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid || out_ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // controller outputs
  always_comb begin
    in_ready = 1'b0;
    rd_issue = 1'b0;
    load_out = 1'b0;
    case (state)
      S_IDLE: in_ready = 1'b1;
      S_SCAN: rd_issue = (rem != '0);
      S_DONE: load_out = !out_valid || out_ready;
      default: ;
    endcase
  end

  assign ram_we = load_out && item_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // store addressing: node selects the block, subset the entry
  assign low         = lowest_bit(rem);
  assign rd_sub_wide = {{MAX_NODES{1'b0}}, sub_r ^ low};
  assign wr_sub_wide = {{MAX_NODES{1'b0}}, sub_r};
  assign ram_addr    = ram_we ? {node_r[NODE_AW-1:0], wr_sub_wide[MAX_NODES-1:0]}
                              : {node_r[NODE_AW-1:0], rd_sub_wide[MAX_NODES-1:0]};
  assign ram_wdata   = {cur_set, cur_score};
  assign rd_set      = ram_rdata[DATA_W-1:SCORE_WIDTH];
  assign rd_score    = ram_rdata[SCORE_WIDTH-1:0];

  bpss_ram #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W),
    .DATA_W (DATA_W)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // member scan control
  always_ff @(posedge clk) begin
    if (rst) begin
      rem        <= '0;
      rd_pending <= 1'b0;
    end else if (in_valid && in_ready) begin
      rem        <= in_ok ? subset : '0;
      rd_pending <= 1'b0;
    end else begin
      if (rd_issue) begin
        rem <= rem & ~low;
      end
      rd_pending <= rd_issue;
    end
  end

  // running best, compared against the entry read last cycle
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      node_r    <= node;
      sub_r     <= subset;
      item_ok   <= in_ok;
      cur_score <= in_ok ? score : '0;
      cur_set   <= in_ok ? subset : '0;
    end else if (rd_pending && (rd_score > cur_score)) begin
      cur_score <= rd_score;
      cur_set   <= rd_set;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      valid_res  <= item_ok;
      best_set   <= cur_set;
      best_score <= cur_score;
    end
  end

`ifndef NO_ASSERTIONS
  // the member mask only loses bits while scanning
  a_rem_shrinks: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN && $past(state == S_SCAN)) |-> ((rem & ~$past(rem)) == '0))
    else $error("member mask gained a bit during scan");

  // an item rejected by the checks never reaches the store
  a_no_bad_write: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (item_ok && state == S_DONE))
    else $error("store written for a rejected item");

  // read data is only consumed in the cycle after a read was issued
  a_rd_pair: assert property (@(posedge clk) disable iff (rst)
    (rd_pending && state == S_SCAN) |-> $past(rd_issue))
    else $error("read data used without a read");

  // no second beat is taken while an item is in flight
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken during item processing");
`endif

endmodule

@@ verif/tb_best_parent_set_subset_dp.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_best_parent_set_subset_dp
// Self-checking bench for the best parent set dynamic program. A queue of
// family scores feeds a valid/ready driver, an in-bench predictor works out
// the best parent set for every accepted beat, and a monitor checks each
// result beat against it. Families are grown so that every one-smaller subset
// is stored before it is read. Phases sweep node_count and the idling mix.
// ----------------------------------------------------------------------------
module tb_best_parent_set_subset_dp;

  import bpss_pkg::*;

  localparam int MAX_NODES    = DEF_MAX_NODES;
  localparam int SCORE_W      = DEF_SCORE_WIDTH;
  localparam int SUBSETS      = 1 << SET_W;
  localparam int STORE_DEPTH  = MAX_NODES * SUBSETS;
  localparam int CLOSURE_MAX  = 32;
  localparam int SETTLE       = 4;
  localparam int END_CYCLES   = 20;
  localparam int STALL_LIMIT  = 4000;

  localparam logic [SCORE_W-1:0] SCORE_MINUS_INF = 32'h8000_0000;
  localparam logic [SCORE_W-1:0] SCORE_TOP       = 32'h7FFF_FFFF;
  localparam logic [SCORE_W-1:0] SCORE_ONE       = 32'h0001_0000;

  typedef enum int {
    IDLE_NONE,
    IDLE_SEND,
    IDLE_RECV,
    IDLE_BOTH
  } idle_mode_t;

  typedef struct packed {
    logic [NODE_W-1:0]  node;
    logic [SET_W-1:0]   subset;
    logic [SCORE_W-1:0] score;
  } family_t;

  typedef struct packed {
    logic               ok;
    logic [SET_W-1:0]   parents;
    logic [SCORE_W-1:0] score;
  } best_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      cfg_we = 1'b0;
  logic [CFG_W-1:0]          cfg_data = '0;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic [NODE_W-1:0]         node = '0;
  logic [SET_W-1:0]          subset = '0;
  logic signed [SCORE_W-1:0] score = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic                      valid_res;
  logic [SET_W-1:0]          best_set;
  logic signed [SCORE_W-1:0] best_score;

  // stimulus side
  family_t    family_q[$];
  bit         gen_stored [STORE_DEPTH];
  int         gen_nodes = MAX_NODES;
  int         send_idle_pct = 0;
  int         recv_stall_pct = 0;

  // predictor side
  best_t              pending_best[$];
  logic [SCORE_W-1:0] kept_score [STORE_DEPTH];
  logic [SET_W-1:0]   kept_set [STORE_DEPTH];
  logic [CFG_W-1:0]   model_nodes;
  int                 err_count = 0;
  int                 idle_cycles = 0;

  best_parent_set_subset_dp DUT (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .node       (node),
    .subset     (subset),
    .score      (score),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .valid_res  (valid_res),
    .best_set   (best_set),
    .best_score (best_score)
  );

  // clock
  initial begin
    forever #1 clk = ~clk;
  end

  // best parent set of one family, updating the kept bests
  function automatic best_t best_parents(input family_t fam);
    best_t res;
    int    n;
    int    base;
    int    addr;
    n   = (model_nodes > MAX_NODES) ? MAX_NODES : int'(model_nodes);
    res = '0;
    if (int'(fam.node) >= n || (int'(fam.subset) >> n) != 0) return res;
    if (fam.subset[fam.node]) return res;
    base        = int'(fam.node) * SUBSETS;
    res.ok      = 1'b1;
    res.parents = fam.subset;
    res.score   = fam.score;
    // lowest member first, strictly greater wins
    for (int b = 0; b < n; b++) begin
      if (fam.subset[b]) begin
        addr = base + (int'(fam.subset) ^ (1 << b));
        if ($signed(kept_score[addr]) > $signed(res.score)) begin
          res.score   = kept_score[addr];
          res.parents = kept_set[addr];
        end
      end
    end
    kept_score[base + int'(fam.subset)] = res.score;
    kept_set[base + int'(fam.subset)]   = res.parents;
    return res;
  endfunction

  // family the block will store under the current node count
  function automatic bit family_valid(input int nd, input int sub);
    return nd < gen_nodes && (sub >> gen_nodes) == 0 && ((sub >> nd) & 1) == 0;
  endfunction

  // invalid, or every one-smaller subset already stored
  function automatic bit family_legal(input int nd, input int sub);
    if (!family_valid(nd, sub)) return 1'b1;
    for (int b = 0; b < SET_W; b++) begin
      if (((sub >> b) & 1) != 0 && !gen_stored[nd * SUBSETS + (sub ^ (1 << b))])
        return 1'b0;
    end
    return 1'b1;
  endfunction

  // subsets of target not yet stored for this node
  function automatic int missing_below(input int nd, input int target);
    int cnt;
    cnt = 0;
    for (int s = 0; s <= target; s++) begin
      if ((s & ~target) == 0 && !gen_stored[nd * SUBSETS + s]) cnt++;
    end
    return cnt;
  endfunction

  // scores: extremes, a tight cluster for ties, and full range
  function automatic logic [SCORE_W-1:0] draw_score();
    case ($urandom_range(0, 9))
      0:          return SCORE_MINUS_INF;
      1:          return SCORE_TOP;
      2, 3, 4, 5: return SCORE_W'((int'($urandom_range(0, 6)) - 3) * 65536);
      default:    return SCORE_W'($urandom);
    endcase
  endfunction

  task automatic queue_family(input int nd, input int sub, input logic [SCORE_W-1:0] sc);
    family_t fam;
    fam.node   = NODE_W'(nd);
    fam.subset = SET_W'(sub);
    fam.score  = sc;
    family_q.push_back(fam);
    if (family_valid(nd, sub)) gen_stored[nd * SUBSETS + sub] = 1'b1;
  endtask

  // grown families with random content, plus random noise
  task automatic fill_random(input int items);
    int nd;
    int target;
    int b;
    int sub;
    while (family_q.size() < items) begin
      if (gen_nodes != 0 && $urandom_range(0, 99) < 75) begin
        nd     = $urandom_range(0, gen_nodes - 1);
        target = int'($urandom) & ((1 << gen_nodes) - 1) & ~(1 << nd);
        while (missing_below(nd, target) > CLOSURE_MAX) begin
          b      = $urandom_range(0, gen_nodes - 1);
          target = target & ~(1 << b);
        end
        if (missing_below(nd, target) == 0) begin
          // whole closure stored: rescore the top subset
          queue_family(nd, target, draw_score());
        end else begin
          for (sub = 0; sub <= target; sub++) begin
            if ((sub & ~target) == 0 && !gen_stored[nd * SUBSETS + sub])
              queue_family(nd, sub, draw_score());
          end
        end
      end else begin
        nd  = $urandom_range(0, (1 << NODE_W) - 1);
        sub = $urandom_range(0, SUBSETS - 1);
        // never read an unwritten entry: push it into its own subset instead
        if (!family_legal(nd, sub)) sub = sub | (1 << nd);
        queue_family(nd, sub, SCORE_W'($urandom));
      end
    end
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (family_q.size() != 0 || in_valid || pending_best.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_node_count(input logic [CFG_W-1:0] v);
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we   <= 1'b0;
    gen_nodes = (v > MAX_NODES) ? MAX_NODES : int'(v);
  endtask

  task automatic set_idling(input idle_mode_t mode);
    send_idle_pct  = (mode == IDLE_SEND) ? 49 : (mode == IDLE_BOTH) ? 6 : 0;
    recv_stall_pct = (mode == IDLE_RECV) ? 49 : (mode == IDLE_BOTH) ? 6 : 0;
  endtask

  task automatic run_phase(input logic [CFG_W-1:0] nodes, input idle_mode_t mode,
                           input int items);
    write_node_count(nodes);
    @(negedge clk);
    set_idling(mode);
    fill_random(items);
    wait_drained();
  endtask

  // main sequence
  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed families at the reset node count
    @(negedge clk);
    set_idling(IDLE_NONE);
    queue_family(0, 'h000, SCORE_TOP);
    queue_family(0, 'h002, SCORE_MINUS_INF);   // stored best takes over
    queue_family(0, 'h004, SCORE_TOP);         // tie keeps own set
    queue_family(0, 'h006, '0);
    queue_family(0, 'h001, SCORE_ONE);         // node in own subset
    queue_family(10, 'h000, SCORE_ONE);        // node beyond count
    queue_family(15, 'h3FF, SCORE_MINUS_INF);
    queue_family(9, 'h000, SCORE_MINUS_INF);
    queue_family(9, 'h100, SCORE_MINUS_INF);
    queue_family(9, 'h001, 32'h8000_0001);
    queue_family(9, 'h101, SCORE_MINUS_INF);   // two members, higher one wins
    queue_family(3, 'h000, SCORE_ONE);
    queue_family(3, 'h200, 32'hFFFF_0000);
    queue_family(3, 'h001, SCORE_MINUS_INF);
    queue_family(3, 'h201, SCORE_MINUS_INF);
    queue_family(0, 'h000, SCORE_MINUS_INF);   // overwrite a stored best
    queue_family(0, 'h002, '0);
    wait_drained();

    // random phases over node counts and idling mixes
    run_phase(4'd4,  IDLE_NONE, 200);
    run_phase(4'd10, IDLE_SEND, 250);
    run_phase(4'd15, IDLE_RECV, 200);
    run_phase(4'd0,  IDLE_BOTH, 30);
    run_phase(4'd1,  IDLE_NONE, 60);
    run_phase(4'd7,  IDLE_RECV, 200);
    run_phase(4'd10, IDLE_BOTH, 250);
    run_phase(4'd2,  IDLE_SEND, 60);
    run_phase(4'd12, IDLE_NONE, 150);
    run_phase(4'd10, IDLE_RECV, 200);

    repeat (END_CYCLES) @(posedge clk);
    if (err_count == 0)
      $display("tb_best_parent_set_subset_dp: done, clean");
    else
      $display("tb_best_parent_set_subset_dp: done, errors");
    $finish;
  end

  // node count copy for the predictor
  always @(posedge clk) begin
    if (rst) begin
      model_nodes <= CFG_W'(MAX_NODES);
    end else if (cfg_we) begin
      model_nodes <= cfg_data;
    end
  end

  // input driver: predict on each accepted beat, then offer the next
  always @(posedge clk) begin : drive
    family_t fam;
    family_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        fam.node   = node;
        fam.subset = subset;
        fam.score  = score;
        pending_best.push_back(best_parents(fam));
      end
      if (!in_valid || in_ready) begin
        if (family_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          nxt      = family_q.pop_front();
          node     <= nxt.node;
          subset   <= nxt.subset;
          score    <= nxt.score;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and receiver stalls
  always @(posedge clk) begin : check
    best_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (pending_best.size() == 0) begin
          $error("result beat with nothing expected: best_set %h", best_set);
          err_count++;
        end else begin
          want = pending_best.pop_front();
          if (valid_res !== want.ok) begin
            $error("valid_res: expected %0b, got %0b", want.ok, valid_res);
            err_count++;
          end
          if (best_set !== want.parents) begin
            $error("best_set: expected %h, got %h", want.parents, best_set);
            err_count++;
          end
          if (best_score !== want.score) begin
            $error("best_score: expected %0d, got %0d", $signed(want.score), best_score);
            err_count++;
          end
        end
      end
      out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // watchdog on cycles without any beat
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == STALL_LIMIT) begin
      $display("tb_best_parent_set_subset_dp: done, errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

@@ sim.f @@
hdl/bpss_pkg.sv
hdl/bpss_ram.sv
hdl/best_parent_set_subset_dp.sv
verif/tb_best_parent_set_subset_dp.sv
